FILE: hdl/tfn_pkg.sv
package tfn_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 16;
  // normalised magnitude width and square-root result width
  localparam int MANT_WIDTH       = 31;
  localparam int ROOT_WIDTH       = 32;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

endpackage

FILE: hdl/tfn_cross.sv
module tfn_cross #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH,
  parameter int MAG_WIDTH   = 2 * COORD_WIDTH + 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic [9*COORD_WIDTH-1:0]       in_data,
  output tfn_pkg::ctl_t                  ctl,
  output logic [2:0][MAG_WIDTH-1:0]      mag
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * COORD_WIDTH + 2;
  localparam int CXW = MAG_WIDTH;

  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] s [3];
  logic signed [COORD_WIDTH-1:0] t [3];
  logic signed [DW-1:0]  a [3];
  logic signed [DW-1:0]  b [3];
  logic signed [PW-1:0]  pr [6];
  logic signed [CXW-1:0] c [3];
  logic                  v1, v2, v3;
  logic [2:0]            neg_next;
  logic [2:0][CXW-1:0]   mag_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = in_data[i*COORD_WIDTH +: COORD_WIDTH];
      s[i] = in_data[(3+i)*COORD_WIDTH +: COORD_WIDTH];
      t[i] = in_data[(6+i)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // edge vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a[i] <= DW'(p[i]) - DW'(s[i]);
        b[i] <= DW'(p[i]) - DW'(t[i]);
      end
    end
  end

  // partial products of the cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      pr[0] <= PW'(a[1]) * PW'(b[2]);
      pr[1] <= PW'(b[1]) * PW'(a[2]);
      pr[2] <= PW'(b[0]) * PW'(a[2]);
      pr[3] <= PW'(a[0]) * PW'(b[2]);
      pr[4] <= PW'(a[0]) * PW'(b[1]);
      pr[5] <= PW'(b[0]) * PW'(a[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        c[i] <= CXW'(pr[2*i]) - CXW'(pr[2*i+1]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_next[i] = c[i][CXW-1];
      mag_next[i] = neg_next[i] ? CXW'(-c[i]) : CXW'(c[i]);
    end
  end

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (ce) begin
      ctl.valid <= v3;
      ctl.degen <= 1'b0;
      ctl.neg   <= neg_next;
    end
    if (ce) begin
      mag <= mag_next;
    end
  end

endmodule

FILE: hdl/tfn_norm.sv
module tfn_norm #(
  parameter int MAG_WIDTH = 2 * tfn_pkg::COORD_WIDTH + 3
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      ce,
  input  tfn_pkg::ctl_t                             in_ctl,
  input  logic [2:0][MAG_WIDTH-1:0]                 mag,
  output tfn_pkg::ctl_t                             ctl,
  output logic [2:0][tfn_pkg::MANT_WIDTH-1:0]       m
);

  localparam int MANT = tfn_pkg::MANT_WIDTH;
  localparam int NW   = (MAG_WIDTH > MANT) ? MAG_WIDTH : MANT;
  localparam int SH   = $clog2(NW);

  tfn_pkg::ctl_t      entry_ctl;
  tfn_pkg::ctl_t      st_ctl [SH+1];
  logic [2:0][NW-1:0] st_v   [SH+1];

  // flag a zero cross product on the way in
  always_comb begin
    entry_ctl       = in_ctl;
    entry_ctl.degen = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_ctl[0] <= '0;
    end else if (ce) begin
      st_ctl[0] <= entry_ctl;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        st_v[0][i] <= NW'(mag[i]) << (NW - MAG_WIDTH);
      end
    end
  end

  // shift all three left together until the largest has its top bit set
  for (genvar j = 0; j < SH; j++) begin : g_shift
    localparam int AMT = 2 ** (SH - 1 - j);
    logic [NW-1:0] any;
    logic          zero_top;

    assign any      = st_v[j][0] | st_v[j][1] | st_v[j][2];
    assign zero_top = (any[NW-1 -: AMT] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[j+1] <= '0;
      end else if (ce) begin
        st_ctl[j+1] <= st_ctl[j];
      end
      if (ce) begin
        for (int i = 0; i < 3; i++) begin
          st_v[j+1][i] <= zero_top ? (st_v[j][i] << AMT) : st_v[j][i];
        end
      end
    end
  end

  assign ctl = st_ctl[SH];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = st_v[SH][i][NW-1 -: MANT];
    end
  end

endmodule

FILE: hdl/tfn_sqrt.sv
module tfn_sqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ce,
  input  tfn_pkg::ctl_t                        in_ctl,
  input  logic [2:0][tfn_pkg::MANT_WIDTH-1:0]  in_m,
  output tfn_pkg::ctl_t                        ctl,
  output logic [2:0][tfn_pkg::MANT_WIDTH-1:0]  m,
  output logic [tfn_pkg::ROOT_WIDTH-1:0]       len
);

  localparam int MANT = tfn_pkg::MANT_WIDTH;
  localparam int ROOT = tfn_pkg::ROOT_WIDTH;
  localparam int SQW  = 2 * MANT;
  localparam int RADW = 2 * ROOT;
  localparam int REMW = ROOT + 3;

  tfn_pkg::ctl_t        sq_ctl;
  logic [2:0][MANT-1:0] sq_m;
  logic [SQW-1:0]       sq [3];

  tfn_pkg::ctl_t        st_ctl  [ROOT+1];
  logic [2:0][MANT-1:0] st_m    [ROOT+1];
  logic [RADW-1:0]      st_rad  [ROOT+1];
  logic [REMW-1:0]      st_rem  [ROOT+1];
  logic [ROOT-1:0]      st_root [ROOT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl <= '0;
    end else if (ce) begin
      sq_ctl <= in_ctl;
    end
    if (ce) begin
      sq_m <= in_m;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQW'(in_m[i]) * SQW'(in_m[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_ctl[0] <= '0;
    end else if (ce) begin
      st_ctl[0] <= sq_ctl;
    end
    if (ce) begin
      st_m[0]    <= sq_m;
      st_rad[0]  <= RADW'(sq[0]) + RADW'(sq[1]) + RADW'(sq[2]);
      st_rem[0]  <= '0;
      st_root[0] <= '0;
    end
  end

  // one root bit per stage, two radicand bits brought down each time
  for (genvar j = 0; j < ROOT; j++) begin : g_root
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    assign rem_sh = {st_rem[j][REMW-3:0], st_rad[j][RADW-1 -: 2]};
    assign trial  = REMW'({st_root[j], 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[j+1] <= '0;
      end else if (ce) begin
        st_ctl[j+1] <= st_ctl[j];
      end
      if (ce) begin
        st_m[j+1]    <= st_m[j];
        st_rad[j+1]  <= st_rad[j] << 2;
        st_rem[j+1]  <= ge ? (rem_sh - trial) : rem_sh;
        st_root[j+1] <= {st_root[j][ROOT-2:0], ge};
      end
    end
  end

  assign ctl = st_ctl[ROOT];
  assign m   = st_m[ROOT];
  assign len = st_root[ROOT];

endmodule

FILE: hdl/tfn_div.sv
module tfn_div #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ce,
  input  tfn_pkg::ctl_t                        in_ctl,
  input  logic [2:0][tfn_pkg::MANT_WIDTH-1:0]  m,
  input  logic [tfn_pkg::ROOT_WIDTH-1:0]       len,
  output tfn_pkg::ctl_t                        ctl,
  output logic [2:0][NORMAL_FRAC_BITS:0]       quo
);

  localparam int MANT = tfn_pkg::MANT_WIDTH;
  localparam int ROOT = tfn_pkg::ROOT_WIDTH;
  localparam int QW   = NORMAL_FRAC_BITS + 1;
  localparam int NUMW = MANT + NORMAL_FRAC_BITS + 1;
  localparam int REMW = ROOT + 1;

  logic [NUMW-1:0] num [3];

  tfn_pkg::ctl_t        st_ctl [QW+1];
  logic [ROOT-1:0]      st_len [QW+1];
  logic [2:0][REMW-1:0] st_rem [QW+1];
  logic [2:0][QW-1:0]   st_low [QW+1];
  logic [2:0][QW-1:0]   st_q   [QW+1];

  // numerator with half the divisor added for round to nearest
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUMW'(m[i]) << NORMAL_FRAC_BITS) + NUMW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_ctl[0] <= '0;
    end else if (ce) begin
      st_ctl[0] <= in_ctl;
    end
    if (ce) begin
      st_len[0] <= len;
      for (int i = 0; i < 3; i++) begin
        st_rem[0][i] <= REMW'(num[i] >> QW);
        st_low[0][i] <= num[i][QW-1:0];
        st_q[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage in each lane
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][REMW-1:0] r;
    logic [2:0]           ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r[i]  = {st_rem[j][i][REMW-2:0], st_low[j][i][QW-1]};
        ge[i] = (r[i] >= REMW'(st_len[j]));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[j+1] <= '0;
      end else if (ce) begin
        st_ctl[j+1] <= st_ctl[j];
      end
      if (ce) begin
        st_len[j+1] <= st_len[j];
        for (int i = 0; i < 3; i++) begin
          st_rem[j+1][i] <= ge[i] ? (r[i] - REMW'(st_len[j])) : r[i];
          st_low[j+1][i] <= st_low[j][i] << 1;
          st_q[j+1][i]   <= {st_q[j][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  assign ctl = st_ctl[QW];
  assign quo = st_q[QW];

endmodule

FILE: hdl/triangle_face_normal_unit.sv
// Throughput: one triangle per cycle unless the output stalls; the 32-stage
//   square root and the one-bit-per-stage division set the depth, not the rate.
// The whole pipeline stalls while a finished word waits on the output.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module triangle_face_normal_unit #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, zero fill
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // normal_x, normal_y, normal_z
  output logic [3*tfn_pkg::OUT_WIDTH-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);

  localparam int MAGW = 2 * COORD_WIDTH + 3;
  localparam int MANT = tfn_pkg::MANT_WIDTH;
  localparam int ROOT = tfn_pkg::ROOT_WIDTH;
  localparam int OUTW = tfn_pkg::OUT_WIDTH;
  localparam int QW   = NORMAL_FRAC_BITS + 1;
  localparam int XW   = (QW > OUTW) ? QW : OUTW;

  logic ce;

  tfn_pkg::ctl_t        cr_ctl, nm_ctl, sq_ctl, dv_ctl;
  logic [2:0][MAGW-1:0] cr_mag;
  logic [2:0][MANT-1:0] nm_m, sq_m;
  logic [ROOT-1:0]      sq_len;
  logic [2:0][QW-1:0]   dv_q;
  logic [2:0][XW-1:0]   sn;

  // advance everything when the output word is free or being taken
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  tfn_cross #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAG_WIDTH   (MAGW)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .in_data  (s_tdata[9*COORD_WIDTH-1:0]),
    .ctl      (cr_ctl),
    .mag      (cr_mag)
  );

  tfn_norm #(
    .MAG_WIDTH (MAGW)
  ) u_norm (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_ctl (cr_ctl),
    .mag    (cr_mag),
    .ctl    (nm_ctl),
    .m      (nm_m)
  );

  tfn_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_ctl (nm_ctl),
    .in_m   (nm_m),
    .ctl    (sq_ctl),
    .m      (sq_m),
    .len    (sq_len)
  );

  tfn_div #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_ctl (sq_ctl),
    .m      (sq_m),
    .len    (sq_len),
    .ctl    (dv_ctl),
    .quo    (dv_q)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sn[i] = dv_ctl.neg[i] ? XW'(-XW'(dv_q[i])) : XW'(dv_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= dv_ctl.valid;
    end
    if (ce) begin
      m_tuser <= dv_ctl.degen;
      for (int i = 0; i < 3; i++) begin
        m_tdata[i*OUTW +: OUTW] <= dv_ctl.degen ? '0 : sn[i][OUTW-1:0];
      end
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate word carries a nonzero normal");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline is stalled");

  a_out_follows_pipe : assert property (@(posedge clk) disable iff (rst)
    ce && dv_ctl.valid |=> m_tvalid)
    else $error("finished item lost at the output register");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CW = tfn_pkg::COORD_WIDTH;
  localparam int FB = tfn_pkg::NORMAL_FRAC_BITS;
  localparam int OW = tfn_pkg::OUT_WIDTH;
  localparam int IN_W = ((9*CW+7)/8)*8;
  localparam int LATENCY = 62;
  localparam int N_RANDOM = 1230;

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          degen;
  } normal_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t tri_t [9];

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [3*OW-1:0] m_tdata;
  logic m_tuser;

  normal_t expected_normals[$];
  int errors = 0;
  int idle_left = 0;
  bit quiet = 0;
  bit hold_off = 0;

  triangle_face_normal_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL triangle_face_normal_unit");
    $finish;
  end

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(tri_t v);
    logic signed [CW+1:0] ea [3];
    logic signed [CW+1:0] eb [3];
    logic signed [127:0] cr [3];
    logic [127:0] mag [3];
    logic [63:0] m [3];
    logic [63:0] sum, len, q;
    int width, w;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      ea[i] = $signed(v[i]) - $signed(v[3+i]);
      eb[i] = $signed(v[i]) - $signed(v[6+i]);
    end
    cr[0] = 128'(ea[1]) * 128'(eb[2]) - 128'(eb[1]) * 128'(ea[2]);
    cr[1] = 128'(eb[0]) * 128'(ea[2]) - 128'(ea[0]) * 128'(eb[2]);
    cr[2] = 128'(ea[0]) * 128'(eb[1]) - 128'(eb[0]) * 128'(ea[1]);
    width = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i][127] ? -cr[i] : cr[i];
      w = 0;
      for (int k = 0; k < 128; k++) if (mag[i][k]) w = k + 1;
      if (w > width) width = w;
    end
    r = '0;
    if (width == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      if (width > 31) m[i] = 64'(mag[i] >> (width - 31));
      else m[i] = 64'(mag[i] << (31 - width));
      m[i] = m[i] & 64'h7FFF_FFFF;
    end
    sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      if (cr[i][127]) q = -q;
      if (i == 0) r.nx = q[OW-1:0];
      else if (i == 1) r.ny = q[OW-1:0];
      else r.nz = q[OW-1:0];
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_triangle(tri_t v);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = v[i];
    return d;
  endfunction

  // offer one word and hold it until it is taken
  task automatic send_triangle(tri_t v, bit typed, normal_t want);
    normal_t p;
    int gap;
    p = face_normal(v);
    if (typed && p != want) begin
      $error("typed row disagrees: expected %h predicted %h", want, p);
      errors++;
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_triangle(v);
    expected_normals.insert(expected_normals.size(), typed ? want : p);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic tri_t random_triangle();
    tri_t v;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: v[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        1: v[i] = CW'($signed(CW'($urandom_range(0, 16))) - 8);
        default: v[i] = CW'($urandom);
      endcase
    end
    // collinear or coincident vertices
    if (mode == 2) for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
    if (mode == 3) for (int i = 0; i < 3; i++) v[6+i] = v[i];
    return v;
  endfunction

  // receiver: random stalls, long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (idle_left > 0) begin
      m_tready <= 1'b0;
      idle_left = idle_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      idle_left = $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_normals.size() == 0) begin
        $error("result word with no expectation: %h %b", m_tdata, m_tuser);
        errors++;
      end else begin
        normal_t e;
        e = expected_normals.pop_front();
        if (m_tdata[0 +: OW] !== e.nx) begin
          $error("normal_x expected %h actual %h", e.nx, m_tdata[0 +: OW]); errors++;
        end
        if (m_tdata[OW +: OW] !== e.ny) begin
          $error("normal_y expected %h actual %h", e.ny, m_tdata[OW +: OW]); errors++;
        end
        if (m_tdata[2*OW +: OW] !== e.nz) begin
          $error("normal_z expected %h actual %h", e.nz, m_tdata[2*OW +: OW]); errors++;
        end
        if (m_tuser !== e.degen) begin
          $error("degenerate expected %b actual %b", e.degen, m_tuser); errors++;
        end
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    int n;
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    n = 0;
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
    hold_off <= 1'b0;
  end

  typedef struct {
    tri_t    v;
    bit      typed;
    normal_t want;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                              int c0, int c1, int c2, bit typed = 0,
                              normal_t want = '0);
    row_t r;
    r.v[0] = CW'(a0); r.v[1] = CW'(a1); r.v[2] = CW'(a2);
    r.v[3] = CW'(b0); r.v[4] = CW'(b1); r.v[5] = CW'(b2);
    r.v[6] = CW'(c0); r.v[7] = CW'(c1); r.v[8] = CW'(c2);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    normal_t degen_w, up_z, down_z, plus_x, plus_y;
    int cnt;
    tri_t v;
    degen_w = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    up_z    = '{nx: '0, ny: '0, nz: 16'h4000, degen: 1'b0};
    down_z  = '{nx: '0, ny: '0, nz: 16'hC000, degen: 1'b0};
    plus_x  = '{nx: 16'h4000, ny: '0, nz: '0, degen: 1'b0};
    plus_y  = '{nx: '0, ny: 16'h4000, nz: '0, degen: 1'b0};

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, degen_w));
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, degen_w));
    add_row(mk(0, 0, 0, -256, 0, 0, 0, -256, 0, 1, up_z));
    add_row(mk(0, 0, 0, 0, -256, 0, -256, 0, 0, 1, down_z));
    add_row(mk(0, 0, 0, 0, -1, 0, 0, 0, -1, 1, plus_x));
    add_row(mk(0, 0, 0, 0, 0, -1, -1, 0, 0, 1, plus_y));
    add_row(mk(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, degen_w));
    add_row(mk(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768));
    add_row(mk(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767));
    add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767));
    add_row(mk(1, 2, 3, 4, 5, 6, 7, 8, 10));
    add_row(mk(-1, -1, -1, 0, 0, 0, 1, 2, 3));
    add_row(mk(100, -200, 300, -400, 500, -600, 700, 800, -900));
    add_row(mk(-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768));
    add_row(mk(1, 1, 1, 1, 1, 0, 1, 0, 0));
    add_row(mk(21845, -21846, 12345, -1, 0, 32767, -32768, 4660, -4661));

    foreach (rows[i]) send_triangle(rows[i].v, rows[i].typed, rows[i].want);

    // drain with the sender idle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_normals.size() != 0) @(posedge clk);

    cnt = 0;
    while (cnt < N_RANDOM) begin
      if (cnt == N_RANDOM - 200) quiet = 1;
      v = random_triangle();
      send_triangle(v, 0, '0);
      cnt++;
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS triangle_face_normal_unit");
    end else begin
      $display("FAIL triangle_face_normal_unit");
    end
    $finish;
  end

endmodule
